@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define STXY_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define STXY_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

// checked at every edge, also during reset
`define STXY_ASSERT_ALWAYS(lbl, ck, cond, msg) \
    lbl: assert property (@(posedge ck) (cond)) else $error(msg);

`endif

@@ hw/rtl/stxy_pkg.sv @@
`default_nettype none

package stxy_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int OUT_FRAC_BITS = 4;

    localparam int POS_W  = 19;
    localparam int LAP_W  = 18;
    localparam int STR_W  = 17;
    localparam int RAD_W  = 16;
    localparam int OFF_W  = 10;
    localparam int SCL_W  = 16;
    localparam int OUT_W  = 20;
    localparam int SEC_W  = 2;
    localparam int CFG_W  = 18;
    localparam int IDX_W  = 3;

    localparam int RQ_W   = RAD_W + SCL_W;
    localparam int LQ_W   = STR_W + SCL_W;
    localparam int PIC_W  = 26;
    localparam int PIRF_W = RQ_W + PIC_W;
    localparam int PIR_W  = PIRF_W - 24;
    localparam int TOT_W  = 36;
    localparam int PROD_W = LAP_W + TOT_W;
    localparam int RR_W   = RQ_W + 1;
    localparam int QA_W   = 30;
    localparam int ANG_W  = QA_W + 2;
    localparam int CW     = 34;
    localparam int TRIG_W = CW - 9;
    localparam int PRD2_W = TRIG_W + RR_W + 1;
    localparam int ACC_W  = PRD2_W - 19;
    localparam int RND_N  = 16 - OUT_FRAC_BITS;

    localparam logic [IDX_W-1:0] REG_LAP      = 3'd0;
    localparam logic [IDX_W-1:0] REG_STRAIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS   = 3'd2;
    localparam logic [IDX_W-1:0] REG_OFFSET   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SCALE    = 3'd4;

    localparam logic [SEC_W-1:0] SEC_UPPER = 2'd0;
    localparam logic [SEC_W-1:0] SEC_RIGHT = 2'd1;
    localparam logic [SEC_W-1:0] SEC_LOWER = 2'd2;
    localparam logic [SEC_W-1:0] SEC_LEFT  = 2'd3;

    localparam logic [PIC_W-1:0] PI_Q24      = 26'd52707179;
    localparam logic [ANG_W-1:0] PI_Q30      = 32'd3373259426;
    localparam logic [ANG_W-1:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032875;

    localparam logic [29:0] ATAN_Q30 [24] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128
    };

endpackage

`default_nettype wire

@@ hw/rtl/stadium_track_position_to_xy_core.sv @@
// throughput: one transaction per cycle while no result is held, set by the fully pipelined dividers and cordic
// a held result stalls the whole pipeline, and the input with it
// reset: asynchronous active low, clears valid bits and loads register defaults
// derived geometry follows a register write in turn: rq and lq, then pir, rr, b1 and half_l, then b2, b3 and total
`default_nettype none

module stadium_track_position_to_xy_core
    import stxy_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    position_valid,
    output logic                         position_stall,
    input  wire logic signed [POS_W-1:0] position_mm,
    output logic                         result_valid,
    input  wire logic                    result_stall,
    output logic signed [OUT_W-1:0]      x_px_q4,
    output logic signed [OUT_W-1:0]      y_px_q4,
    output logic [SEC_W-1:0]             section,
    input  wire logic                    cfg_we,
    input  wire logic [IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_wdata
);

    localparam int P_IDX  = POS_W + 1;
    localparam int D_BASE = P_IDX + 1;
    localparam int G_BASE = D_BASE + TOT_W + 1;
    localparam int C_BASE = G_BASE + QA_W + 1;
    localparam int NSTG   = C_BASE + CORDIC_STEPS + 1 + 3;

    logic en;
    logic [NSTG-1:0] vld_reg;
    logic result_valid_reg;

    // configuration
    logic [LAP_W-1:0] lap_reg;
    logic [STR_W-1:0] str_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [OFF_W-1:0] off_reg;
    logic [SCL_W-1:0] scl_reg;
    logic [LAP_W-1:0] lap_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lap_reg <= 18'd126000;
            str_reg <= 17'd40000;
            rad_reg <= 16'd2500;
            off_reg <= 10'd20;
            scl_reg <= 16'd655;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LAP:      lap_reg <= cfg_wdata[LAP_W-1:0];
                REG_STRAIGHT: str_reg <= cfg_wdata[STR_W-1:0];
                REG_RADIUS:   rad_reg <= cfg_wdata[RAD_W-1:0];
                REG_OFFSET:   off_reg <= cfg_wdata[OFF_W-1:0];
                REG_SCALE:    scl_reg <= cfg_wdata[SCL_W-1:0];
                default:      ;
            endcase
        end
    end

    assign lap_eff = (lap_reg == '0) ? LAP_W'(1) : lap_reg;

    // derived geometry in q16 pixels
    logic [RQ_W-1:0]   rq_reg;
    logic [LQ_W-1:0]   lq_reg;
    logic [PIR_W-1:0]  pir_reg;
    logic [RR_W-1:0]   rr_reg;
    logic [TOT_W-1:0]  b1_reg;
    logic [TOT_W-1:0]  b2_reg;
    logic [TOT_W-1:0]  b3_reg;
    logic [TOT_W-1:0]  total_reg;
    logic [LQ_W-2:0]   half_l_reg;
    logic [PIRF_W-1:0] pir_full;

    assign pir_full = PIRF_W'(rq_reg) * PIRF_W'(PI_Q24) + (PIRF_W'(1) << 23);

    always_ff @(posedge clk)
    begin
        rq_reg     <= RQ_W'(rad_reg) * RQ_W'(scl_reg);
        lq_reg     <= LQ_W'(str_reg) * LQ_W'(scl_reg);
        pir_reg    <= pir_full[PIRF_W-1:24];
        rr_reg     <= RR_W'(rq_reg) + RR_W'({off_reg, 16'd0});
        b1_reg     <= TOT_W'(lq_reg);
        b2_reg     <= TOT_W'(lq_reg) + TOT_W'(pir_reg);
        b3_reg     <= TOT_W'(lq_reg) + TOT_W'(lq_reg) + TOT_W'(pir_reg);
        total_reg  <= TOT_W'(lq_reg) + TOT_W'(lq_reg) + TOT_W'(pir_reg) + TOT_W'(pir_reg);
        half_l_reg <= lq_reg[LQ_W-1:1];
    end

    // handshake and valid line
    assign en             = !(result_valid_reg && result_stall);
    assign position_stall = !en;
    assign result_valid   = result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg          <= {vld_reg[NSTG-2:0], position_valid};
            result_valid_reg <= vld_reg[NSTG-1];
        end
    end

    // floored modulo of position by lap length
    logic             m_neg_reg [0:POS_W];
    logic [POS_W-1:0] m_abs_reg [0:POS_W];
    logic [LAP_W-1:0] m_rem_reg [0:POS_W];
    logic [LAP_W-1:0] m_rem_next [1:POS_W];
    logic [POS_W-1:0] abs_in;

    assign abs_in = position_mm[POS_W-1] ? POS_W'(-position_mm) : POS_W'(position_mm);

    for (genvar k = 0; k < POS_W; k++)
    begin : g_mod
        logic [LAP_W:0] trial;
        assign trial = {m_rem_reg[k], m_abs_reg[k][POS_W-1-k]};
        assign m_rem_next[k+1] = (trial >= {1'b0, lap_eff}) ?
                                 LAP_W'(trial - {1'b0, lap_eff}) : trial[LAP_W-1:0];
    end

    logic [LAP_W-1:0] p_reg;
    logic [LAP_W-1:0] p_next;

    assign p_next = (m_neg_reg[POS_W] && m_rem_reg[POS_W] != '0) ?
                    LAP_W'(lap_eff - m_rem_reg[POS_W]) : m_rem_reg[POS_W];

    // lap fraction onto track length: p * total / lap
    logic [TOT_W-1:0]  d_low_reg  [0:TOT_W];
    logic [LAP_W-1:0]  d_rem_reg  [0:TOT_W];
    logic [TOT_W-1:0]  d_q_reg    [0:TOT_W];
    logic [LAP_W-1:0]  d_rem_next [1:TOT_W];
    logic [TOT_W-1:0]  d_q_next   [1:TOT_W];
    logic [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(p_reg) * PROD_W'(total_reg);

    for (genvar j = 0; j < TOT_W; j++)
    begin : g_div
        logic [LAP_W:0] trial;
        logic           ge;
        assign trial = {d_rem_reg[j], d_low_reg[j][TOT_W-1-j]};
        assign ge    = trial >= {1'b0, lap_eff};
        assign d_rem_next[j+1] = ge ? LAP_W'(trial - {1'b0, lap_eff}) : trial[LAP_W-1:0];
        assign d_q_next[j+1]   = {d_q_reg[j][TOT_W-2:0], ge};
    end

    // section decode
    logic [TOT_W-1:0]        pos;
    logic [SEC_W-1:0]        sec_next;
    logic [PIR_W-1:0]        arc_next;
    logic signed [ACC_W-1:0] sx_next;
    logic signed [ACC_W-1:0] sy_next;

    assign pos = d_q_reg[TOT_W];

    always_comb
    begin
        logic signed [ACC_W-1:0] pos_s;
        logic signed [ACC_W-1:0] half_s;
        logic signed [ACC_W-1:0] rr_s;
        logic signed [ACC_W-1:0] b2_s;
        pos_s    = signed'(ACC_W'(pos));
        half_s   = signed'(ACC_W'(half_l_reg));
        rr_s     = signed'(ACC_W'(rr_reg));
        b2_s     = signed'(ACC_W'(b2_reg));
        sec_next = SEC_LEFT;
        arc_next = '0;
        sx_next  = '0;
        sy_next  = '0;
        if (pos < b1_reg)
        begin
            sec_next = SEC_UPPER;
            sx_next  = pos_s - half_s;
            sy_next  = -rr_s;
        end
        else if (pos < b2_reg)
        begin
            sec_next = SEC_RIGHT;
            arc_next = PIR_W'(pos - b1_reg);
        end
        else if (pos < b3_reg)
        begin
            sec_next = SEC_LOWER;
            sx_next  = half_s - (pos_s - b2_s);
            sy_next  = rr_s;
        end
        else
        begin
            arc_next = PIR_W'(pos - b3_reg);
        end
    end

    // arc angle: (arc << 28) / rq
    logic [SEC_W-1:0]        g_sec_reg  [0:QA_W];
    logic signed [ACC_W-1:0] g_x_reg    [0:QA_W];
    logic signed [ACC_W-1:0] g_y_reg    [0:QA_W];
    logic [RQ_W-1:0]         g_rem_reg  [0:QA_W];
    logic [1:0]              g_lo_reg   [0:QA_W];
    logic [QA_W-1:0]         g_q_reg    [0:QA_W];
    logic [RQ_W-1:0]         g_rem_next [1:QA_W];
    logic [QA_W-1:0]         g_q_next   [1:QA_W];

    for (genvar j = 0; j < QA_W; j++)
    begin : g_ang
        logic [RQ_W:0] trial;
        logic          ge;
        logic          nb;
        if (j < 2)
        begin : g_bit
            assign nb = g_lo_reg[j][1-j];
        end
        else
        begin : g_zero
            assign nb = 1'b0;
        end
        assign trial = {g_rem_reg[j], nb};
        assign ge    = trial >= {1'b0, rq_reg};
        assign g_rem_next[j+1] = ge ? RQ_W'(trial - {1'b0, rq_reg}) : trial[RQ_W-1:0];
        assign g_q_next[j+1]   = {g_q_reg[j][QA_W-2:0], ge};
    end

    // angle clamp and quadrant fold
    logic [ANG_W-1:0] ang;
    logic [ANG_W-1:0] ang_c;
    logic             swap_next;
    logic [ANG_W-1:0] z_next;

    assign ang       = (rq_reg == '0) ? '0 : {g_q_reg[QA_W], 2'b00};
    assign ang_c     = (ang > PI_Q30) ? PI_Q30 : ang;
    assign swap_next = ang_c > HALF_PI_Q30;
    assign z_next    = swap_next ? ang_c - HALF_PI_Q30 : ang_c;

    // cordic rotation
    logic [SEC_W-1:0]        c_sec_reg  [0:CORDIC_STEPS];
    logic signed [ACC_W-1:0] c_x_reg    [0:CORDIC_STEPS];
    logic signed [ACC_W-1:0] c_y_reg    [0:CORDIC_STEPS];
    logic                    c_swap_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0]    c_cos_reg  [0:CORDIC_STEPS];
    logic signed [CW-1:0]    c_sin_reg  [0:CORDIC_STEPS];
    logic signed [CW-1:0]    c_ang_reg  [0:CORDIC_STEPS];
    logic signed [CW-1:0]    c_cos_next [1:CORDIC_STEPS];
    logic signed [CW-1:0]    c_sin_next [1:CORDIC_STEPS];
    logic signed [CW-1:0]    c_ang_next [1:CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] at;
        assign dx = c_sin_reg[i] >>> i;
        assign dy = c_cos_reg[i] >>> i;
        assign at = signed'(CW'(ATAN_Q30[i]));
        assign c_cos_next[i+1] = c_ang_reg[i][CW-1] ? c_cos_reg[i] + dx : c_cos_reg[i] - dx;
        assign c_sin_next[i+1] = c_ang_reg[i][CW-1] ? c_sin_reg[i] - dy : c_sin_reg[i] + dy;
        assign c_ang_next[i+1] = c_ang_reg[i][CW-1] ? c_ang_reg[i] + at : c_ang_reg[i] - at;
    end

    // trig select and round to q20
    logic signed [CW-1:0]   sn_raw;
    logic signed [CW-1:0]   cs_raw;
    logic signed [CW:0]     sn_sum;
    logic signed [CW:0]     cs_sum;

    assign sn_raw = c_swap_reg[CORDIC_STEPS] ? c_cos_reg[CORDIC_STEPS] : c_sin_reg[CORDIC_STEPS];
    assign cs_raw = c_swap_reg[CORDIC_STEPS] ? -c_sin_reg[CORDIC_STEPS] : c_cos_reg[CORDIC_STEPS];
    assign sn_sum = (CW+1)'(sn_raw) + (CW+1)'(512);
    assign cs_sum = (CW+1)'(cs_raw) + (CW+1)'(512);

    logic [SEC_W-1:0]         t_sec_reg;
    logic signed [ACC_W-1:0]  t_x_reg;
    logic signed [ACC_W-1:0]  t_y_reg;
    logic signed [TRIG_W-1:0] t_sn_reg;
    logic signed [TRIG_W-1:0] t_cs_reg;

    // scale by outward radius
    logic [SEC_W-1:0]         u_sec_reg;
    logic signed [ACC_W-1:0]  u_x_reg;
    logic signed [ACC_W-1:0]  u_y_reg;
    logic signed [PRD2_W-1:0] u_sn_reg;
    logic signed [PRD2_W-1:0] u_cs_reg;
    logic signed [PRD2_W-1:0] rr_w;

    assign rr_w = signed'(PRD2_W'(rr_reg));

    // combine with arc centres
    logic signed [PRD2_W:0]  sn_r;
    logic signed [PRD2_W:0]  cs_r;
    logic signed [ACC_W-1:0] sn_q;
    logic signed [ACC_W-1:0] cs_q;
    logic signed [ACC_W-1:0] half_w;
    logic signed [ACC_W-1:0] vx_next;
    logic signed [ACC_W-1:0] vy_next;

    assign sn_r   = (PRD2_W+1)'(u_sn_reg) + (PRD2_W+1)'(1 << 19);
    assign cs_r   = (PRD2_W+1)'(u_cs_reg) + (PRD2_W+1)'(1 << 19);
    assign sn_q   = sn_r[PRD2_W:20];
    assign cs_q   = cs_r[PRD2_W:20];
    assign half_w = signed'(ACC_W'(half_l_reg));

    always_comb
    begin
        vx_next = u_x_reg;
        vy_next = u_y_reg;
        case (u_sec_reg)
            SEC_RIGHT:
            begin
                vx_next = half_w + sn_q;
                vy_next = -cs_q;
            end
            SEC_LEFT:
            begin
                vx_next = -half_w - sn_q;
                vy_next = cs_q;
            end
            default: ;
        endcase
    end

    logic [SEC_W-1:0]        v_sec_reg;
    logic signed [ACC_W-1:0] v_x_reg;
    logic signed [ACC_W-1:0] v_y_reg;

    function automatic logic [OUT_W-1:0] to_field(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W:0] s;
        logic signed [ACC_W:0] q;
        s = (ACC_W+1)'(v) + (ACC_W+1)'(1 << (RND_N - 1));
        q = s >>> RND_N;
        if (q > (ACC_W+1)'(signed'(OUT_W'({1'b0, {(OUT_W-1){1'b1}}}))))
            to_field = {1'b0, {(OUT_W-1){1'b1}}};
        else if (q < -((ACC_W+1)'(1) <<< (OUT_W-1)))
            to_field = {1'b1, {(OUT_W-1){1'b0}}};
        else
            to_field = q[OUT_W-1:0];
    endfunction

    logic signed [OUT_W-1:0] x_reg;
    logic signed [OUT_W-1:0] y_reg;
    logic [SEC_W-1:0]        sec_reg;

    assign x_px_q4 = x_reg;
    assign y_px_q4 = y_reg;
    assign section = sec_reg;

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_neg_reg[0] <= position_mm[POS_W-1];
            m_abs_reg[0] <= abs_in;
            m_rem_reg[0] <= '0;
            for (int k = 1; k <= POS_W; k++)
            begin
                m_neg_reg[k] <= m_neg_reg[k-1];
                m_abs_reg[k] <= m_abs_reg[k-1];
                m_rem_reg[k] <= m_rem_next[k];
            end
            p_reg <= p_next;

            d_rem_reg[0] <= prod_next[PROD_W-1:TOT_W];
            d_low_reg[0] <= prod_next[TOT_W-1:0];
            d_q_reg[0]   <= '0;
            for (int j = 1; j <= TOT_W; j++)
            begin
                d_rem_reg[j] <= d_rem_next[j];
                d_low_reg[j] <= d_low_reg[j-1];
                d_q_reg[j]   <= d_q_next[j];
            end

            g_sec_reg[0] <= sec_next;
            g_x_reg[0]   <= sx_next;
            g_y_reg[0]   <= sy_next;
            g_rem_reg[0] <= arc_next[PIR_W-1:2];
            g_lo_reg[0]  <= arc_next[1:0];
            g_q_reg[0]   <= '0;
            for (int j = 1; j <= QA_W; j++)
            begin
                g_sec_reg[j] <= g_sec_reg[j-1];
                g_x_reg[j]   <= g_x_reg[j-1];
                g_y_reg[j]   <= g_y_reg[j-1];
                g_rem_reg[j] <= g_rem_next[j];
                g_lo_reg[j]  <= g_lo_reg[j-1];
                g_q_reg[j]   <= g_q_next[j];
            end

            c_sec_reg[0]  <= g_sec_reg[QA_W];
            c_x_reg[0]    <= g_x_reg[QA_W];
            c_y_reg[0]    <= g_y_reg[QA_W];
            c_swap_reg[0] <= swap_next;
            c_cos_reg[0]  <= CORDIC_GAIN_Q30;
            c_sin_reg[0]  <= '0;
            c_ang_reg[0]  <= signed'(CW'(z_next));
            for (int i = 1; i <= CORDIC_STEPS; i++)
            begin
                c_sec_reg[i]  <= c_sec_reg[i-1];
                c_x_reg[i]    <= c_x_reg[i-1];
                c_y_reg[i]    <= c_y_reg[i-1];
                c_swap_reg[i] <= c_swap_reg[i-1];
                c_cos_reg[i]  <= c_cos_next[i];
                c_sin_reg[i]  <= c_sin_next[i];
                c_ang_reg[i]  <= c_ang_next[i];
            end

            t_sec_reg <= c_sec_reg[CORDIC_STEPS];
            t_x_reg   <= c_x_reg[CORDIC_STEPS];
            t_y_reg   <= c_y_reg[CORDIC_STEPS];
            t_sn_reg  <= sn_sum[CW:10];
            t_cs_reg  <= cs_sum[CW:10];

            u_sec_reg <= t_sec_reg;
            u_x_reg   <= t_x_reg;
            u_y_reg   <= t_y_reg;
            u_sn_reg  <= PRD2_W'(t_sn_reg) * rr_w;
            u_cs_reg  <= PRD2_W'(t_cs_reg) * rr_w;

            v_sec_reg <= u_sec_reg;
            v_x_reg   <= vx_next;
            v_y_reg   <= vy_next;

            x_reg   <= to_field(v_x_reg);
            y_reg   <= to_field(v_y_reg);
            sec_reg <= v_sec_reg;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/stxy_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module stxy_checker
    import stxy_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    position_stall,
    input wire logic                    result_valid,
    input wire logic                    result_stall,
    input wire logic signed [OUT_W-1:0] x_px_q4,
    input wire logic signed [OUT_W-1:0] y_px_q4,
    input wire logic [SEC_W-1:0]        section
);

    // held transaction stays put
    `STXY_ASSERT_NEXT(a_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(x_px_q4) && $stable(y_px_q4) && $stable(section), "stalled result changed")

    // input only backs up behind a held result
    `STXY_ASSERT_IMPL(a_stall, clk, rst_n, position_stall, result_valid && result_stall, "input stalled without output stall")

    // upper straight sits above the centre line, lower below
    `STXY_ASSERT_IMPL(a_upper, clk, rst_n, result_valid && section == SEC_UPPER, y_px_q4[OUT_W-1] || y_px_q4 == '0, "upper straight with positive y")
    `STXY_ASSERT_IMPL(a_lower, clk, rst_n, result_valid && section == SEC_LOWER, !y_px_q4[OUT_W-1], "lower straight with negative y")

    // nothing offered once reset has been seen at an edge
    `STXY_ASSERT_NEXT(a_reset, clk, 1'b1, !rst_n, !result_valid, "result valid during reset")

endmodule

bind stadium_track_position_to_xy_core stxy_checker u_stxy_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .position_stall (position_stall),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .x_px_q4        (x_px_q4),
    .y_px_q4        (y_px_q4),
    .section        (section)
);

`default_nettype wire

@@ dv/stadium_track_position_to_xy_core_test.sv @@
`default_nettype none

module stadium_track_position_to_xy_core_test;
    import stxy_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 130;
    localparam int MAX_MISMATCH_PRINT = 10;

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic [SEC_W-1:0]        sec;
    } track_point_t;

    typedef struct {
        logic signed [POS_W-1:0] pos;
        bit                      typed;
        track_point_t            want;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    position_valid;
    logic                    position_stall;
    logic signed [POS_W-1:0] position_mm;
    logic                    result_valid;
    logic                    result_stall;
    logic signed [OUT_W-1:0] x_px_q4;
    logic signed [OUT_W-1:0] y_px_q4;
    logic [SEC_W-1:0]        section;
    logic                    cfg_we;
    logic [IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]        cfg_wdata;

    // shadow copy of the geometry registers
    logic [LAP_W-1:0] sh_lap;
    logic [STR_W-1:0] sh_straight;
    logic [RAD_W-1:0] sh_radius;
    logic [OFF_W-1:0] sh_offset;
    logic [SCL_W-1:0] sh_scale;

    track_point_t pending_points[$];
    int  mismatches;
    int  unexpected;
    int  sent_count;
    int  checked_count;
    int  phase_count;
    int  idle_cycles;
    int  stall_left;
    bit  stall_burst;
    bit  quiet;
    int  sec_seen[4];

    stadium_track_position_to_xy_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .position_valid (position_valid),
        .position_stall (position_stall),
        .position_mm    (position_mm),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .x_px_q4        (x_px_q4),
        .y_px_q4        (y_px_q4),
        .section        (section),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [OUT_W-1:0] q16_to_field(input longint v);
        longint t;
        begin
            t = (v + (longint'(1) <<< (RND_N - 1))) >>> RND_N;
            if (t > 524287)
                t = 524287;
            if (t < -524288)
                t = -524288;
            return t[OUT_W-1:0];
        end
    endfunction

    function automatic track_point_t locate_on_track(input logic signed [POS_W-1:0] pmm);
        track_point_t res;
        longint v, lap, r, rr, half_l, x, y, sn, cs, ang, cx, cy, cz, dx, dy;
        longint unsigned p, rq, lq, pir, total, pos, b1, b2, b3, s;
        logic [SEC_W-1:0] sec;
        begin
            v = pmm;
            lap = (sh_lap == 0) ? 1 : longint'(sh_lap);
            r = v % lap;
            if (r < 0)
                r += lap;
            p = r;
            rq = longint'(sh_radius) * longint'(sh_scale);
            lq = longint'(sh_straight) * longint'(sh_scale);
            pir = (rq * longint'(PI_Q24) + (longint'(1) << 23)) >> 24;
            total = 2 * lq + 2 * pir;
            pos = p * total / longint'(lap);
            b1 = lq;
            b2 = b1 + pir;
            b3 = b2 + lq;
            rr = longint'(rq) + (longint'(sh_offset) <<< 16);
            half_l = longint'(lq >> 1);
            sn = 0;
            cs = 0;
            if (pos < b1)
            begin
                sec = SEC_UPPER;
                s = 0;
            end
            else if (pos < b2)
            begin
                sec = SEC_RIGHT;
                s = pos - b1;
            end
            else if (pos < b3)
            begin
                sec = SEC_LOWER;
                s = 0;
            end
            else
            begin
                sec = SEC_LEFT;
                s = pos - b3;
            end
            if (sec == SEC_RIGHT || sec == SEC_LEFT)
            begin
                ang = (rq != 0) ? longint'(((s << 28) / rq) << 2) : 0;
                if (ang > longint'(PI_Q30))
                    ang = longint'(PI_Q30);
                cx = longint'(CORDIC_GAIN_Q30);
                cy = 0;
                cz = (ang > longint'(HALF_PI_Q30)) ? ang - longint'(HALF_PI_Q30) : ang;
                for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
                begin
                    dx = cy >>> i;
                    dy = cx >>> i;
                    if (cz >= 0)
                    begin
                        cx -= dx;
                        cy += dy;
                        cz -= longint'(ATAN_Q30[i]);
                    end
                    else
                    begin
                        cx += dx;
                        cy -= dy;
                        cz += longint'(ATAN_Q30[i]);
                    end
                end
                // above a quarter turn sine and cosine swap roles
                if (ang > longint'(HALF_PI_Q30))
                begin
                    sn = cx;
                    cs = -cy;
                end
                else
                begin
                    sn = cy;
                    cs = cx;
                end
                sn = ((((sn + 512) >>> 10) * rr) + (longint'(1) <<< 19)) >>> 20;
                cs = ((((cs + 512) >>> 10) * rr) + (longint'(1) <<< 19)) >>> 20;
            end
            case (sec)
                SEC_UPPER:
                begin
                    x = longint'(pos) - half_l;
                    y = -rr;
                end
                SEC_RIGHT:
                begin
                    x = half_l + sn;
                    y = -cs;
                end
                SEC_LOWER:
                begin
                    x = half_l - longint'(pos - b2);
                    y = rr;
                end
                default:
                begin
                    x = -half_l - sn;
                    y = cs;
                end
            endcase
            res.x = q16_to_field(x);
            res.y = q16_to_field(y);
            res.sec = sec;
            return res;
        end
    endfunction

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_position(input logic signed [POS_W-1:0] pmm, input bit typed,
                                 input track_point_t want);
        track_point_t exp_pt;
        begin
            position_valid <= 1'b1;
            position_mm <= pmm;
            do
                @(posedge clk);
            while (position_stall);
            exp_pt = typed ? want : locate_on_track(pmm);
            pending_points.push_back(exp_pt);
            sent_count++;
        end
    endtask

    task automatic sender_gap();
        int gap;
        begin
            gap = 0;
            if (!quiet)
            begin
                if ($urandom_range(0, 24) == 0)
                    gap = $urandom_range(15, 60);
                else if ($urandom_range(0, 1) == 0)
                    gap = $urandom_range(1, 3);
            end
            if (gap > 0)
            begin
                position_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        begin
            position_valid <= 1'b0;
            while (pending_points.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic program_track(input logic [CFG_W-1:0] lap, input logic [CFG_W-1:0] str,
                                 input logic [CFG_W-1:0] rad, input logic [CFG_W-1:0] off,
                                 input logic [CFG_W-1:0] scl);
        logic [CFG_W-1:0] vals[8];
        begin
            vals[REG_LAP] = lap;
            vals[REG_STRAIGHT] = str;
            vals[REG_RADIUS] = rad;
            vals[REG_OFFSET] = off;
            vals[REG_SCALE] = scl;
            // indexes past the last register must be ignored
            vals[5] = CFG_W'($urandom);
            vals[6] = CFG_W'($urandom);
            vals[7] = CFG_W'($urandom);
            for (int i = 7; i >= 0; i--)
            begin
                cfg_we <= 1'b1;
                cfg_index <= i[IDX_W-1:0];
                cfg_wdata <= vals[i];
                @(posedge clk);
            end
            cfg_we <= 1'b0;
            sh_lap = lap[LAP_W-1:0];
            sh_straight = str[STR_W-1:0];
            sh_radius = rad[RAD_W-1:0];
            sh_offset = off[OFF_W-1:0];
            sh_scale = scl[SCL_W-1:0];
            repeat (8) @(posedge clk);
        end
    endtask

    function automatic logic signed [POS_W-1:0] random_position();
        longint lap, v;
        begin
            lap = (sh_lap == 0) ? 1 : longint'(sh_lap);
            case ($urandom_range(0, 3))
                0: v = $urandom;
                1: v = longint'($urandom_range(0, 4)) * lap - 4 + $urandom_range(0, 8);
                default: v = $urandom_range(0, int'(lap - 1));
            endcase
            if ($urandom_range(0, 5) == 0)
                v = -v;
            return v[POS_W-1:0];
        end
    endfunction

    task automatic random_items(input int n);
        track_point_t none;
        begin
            none = '{x: '0, y: '0, sec: SEC_UPPER};
            for (int i = 0; i < n; i++)
            begin
                send_position(random_position(), 1'b0, none);
                sender_gap();
            end
        end
    endtask

    // result side: check, pick the next stall
    always @(posedge clk)
    begin
        track_point_t got;
        track_point_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = '{x: x_px_q4, y: y_px_q4, sec: section};
            if (pending_points.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= MAX_MISMATCH_PRINT)
                    $display("unexpected transaction x=%0d y=%0d section=%0d",
                             got.x, got.y, got.sec);
            end
            else
            begin
                want = pending_points.pop_front();
                checked_count++;
                sec_seen[got.sec]++;
                if (got.x !== want.x || got.y !== want.y || got.sec !== want.sec)
                begin
                    mismatches++;
                    if (mismatches + unexpected <= MAX_MISMATCH_PRINT)
                        $display({"mismatch: expected x=%0d y=%0d section=%0d, ",
                                  "got x=%0d y=%0d section=%0d"},
                                 want.x, want.y, want.sec, got.x, got.y, got.sec);
                end
            end
        end
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (quiet)
        begin
            stall_burst <= 1'b0;
            result_stall <= 1'b0;
        end
        else
        begin
            stall_burst <= !stall_burst;
            result_stall <= !stall_burst;
            if ($urandom_range(0, 19) == 0)
                stall_left <= $urandom_range(20, 80);
            else
                stall_left <= $urandom_range(0, 4);
        end
    end

    always @(posedge clk)
    begin
        if ((position_valid && !position_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_points.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        track_point_t home;
        track_point_t none;
        home = '{x: -20'sd3198, y: -20'sd720, sec: SEC_UPPER};
        none = '{x: '0, y: '0, sec: SEC_UPPER};
        rst_n = 1'b0;
        position_valid = 1'b0;
        position_mm = '0;
        result_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        mismatches = 0;
        unexpected = 0;
        sent_count = 0;
        checked_count = 0;
        phase_count = 0;
        idle_cycles = 0;
        stall_left = 0;
        stall_burst = 1'b0;
        quiet = 1'b0;
        sec_seen = '{0, 0, 0, 0};
        sh_lap = 126000;
        sh_straight = 40000;
        sh_radius = 2500;
        sh_offset = 20;
        sh_scale = 655;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // reset geometry: lap start, wraps, both arcs, both straights
        rows = '{
            '{pos: 0,       typed: 1, want: home},
            '{pos: 126000,  typed: 1, want: home},
            '{pos: -126000, typed: 1, want: home},
            '{pos: -262144, typed: 0, want: none},
            '{pos: 262143,  typed: 0, want: none},
            '{pos: -1,      typed: 0, want: none},
            '{pos: 125999,  typed: 0, want: none},
            '{pos: 52660,   typed: 0, want: none},
            '{pos: 55000,   typed: 0, want: none},
            '{pos: 60000,   typed: 0, want: none},
            '{pos: 62900,   typed: 0, want: none},
            '{pos: 90000,   typed: 0, want: none},
            '{pos: 115700,  typed: 0, want: none},
            '{pos: 118000,  typed: 0, want: none},
            '{pos: 122000,  typed: 0, want: none},
            '{pos: 125500,  typed: 0, want: none}
        };
        foreach (rows[i])
        begin
            send_position(rows[i].pos, rows[i].typed, rows[i].want);
            sender_gap();
        end
        wait_drained();

        // zero lap length acts as one, so every position lands at the lap start
        program_track(0, 40000, 2500, 20, 655);
        send_position(POS_W'(-262144), 1'b1, home);
        send_position(19'sd262143, 1'b1, home);
        send_position(19'sd12345, 1'b1, home);
        wait_drained();

        // extremes: saturating geometry, tiny geometry, zero radius, zero scale, circle
        program_track(262143, 131071, 65535, 1023, 65535);
        random_items(70);
        wait_drained();
        phase_count++;
        program_track(1, 0, 1, 0, 1);
        random_items(30);
        wait_drained();
        phase_count++;
        program_track(126000, 40000, 0, 20, 655);
        random_items(50);
        wait_drained();
        phase_count++;
        program_track(CFG_W'($urandom_range(1, 262143)), 40000, 2500, 1023, 0);
        random_items(40);
        wait_drained();
        phase_count++;
        program_track(100000, 0, 30000, CFG_W'($urandom_range(0, 1023)), 3000);
        random_items(60);
        wait_drained();
        phase_count++;

        for (int ph = 0; ph < 7; ph++)
        begin
            quiet = (ph % 3 == 2);
            program_track(CFG_W'($urandom_range(1, 262143)),
                          CFG_W'($urandom_range(0, 131071)),
                          CFG_W'($urandom_range(1, 65535)),
                          CFG_W'($urandom_range(0, 1023)),
                          CFG_W'($urandom_range(1, 65535)));
            random_items(65);
            wait_drained();
            phase_count++;
        end
        quiet = 1'b0;

        $display("sent %0d positions over %0d track settings, checked %0d results",
                 sent_count, phase_count + 2, checked_count);
        $display("sections seen: upper %0d, right %0d, lower %0d, left %0d",
                 sec_seen[0], sec_seen[1], sec_seen[2], sec_seen[3]);
        if (mismatches == 0 && unexpected == 0 && pending_points.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
